### rtl/tcce_pkg.sv
package tcce_pkg;

   localparam int ROW_CNT_W  = 7;
   localparam int COL_CNT_W  = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RESET = 7'd24;
   localparam logic [COL_CNT_W-1:0] COL_COUNT_RESET = 8'd80;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_code;
      logic [5:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0] read_char;
      logic [5:0] cursor_row;
      logic [7:0] cursor_col;
      logic       scrolled;
      logic       cleared;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_READ,
      OP_NOP,
      OP_BS,
      OP_CR,
      OP_LF,
      OP_FF,
      OP_PUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_code;
      logic [5:0] read_row;
      logic [6:0] read_col;
   } item_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage

### rtl/tcce_front.sv
module tcce_front
   import tcce_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   input  back_status_type status,
   output logic            q_valid,
   output item_type        q_item,
   input  logic            q_pop
);

   item_type   fifo_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   item_type   item_in;
   logic       push;
   logic       pop;

   // Decode the byte once here so that the back end only sees an operation.
   always_comb begin
      item_in.char_code = req_data.char_code;
      item_in.read_row  = req_data.read_row;
      item_in.read_col  = req_data.read_col;
      if (req_data.cmd == CMD_READ) begin
         item_in.op = OP_READ;
      end else begin
         case (req_data.char_code)
            CHAR_NUL: item_in.op = OP_NOP;
            CHAR_BS:  item_in.op = OP_BS;
            CHAR_CR:  item_in.op = OP_CR;
            CHAR_LF:  item_in.op = OP_LF;
            CHAR_FF:  item_in.op = OP_FF;
            default:  item_in.op = OP_PUT;
         endcase
      end
   end

   assign req_stall = (count_ff == 2'd2) || status.init_busy;
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = fifo_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

### rtl/tcce_back.sv
module tcce_back
   import tcce_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output back_status_type       status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   localparam int RIW   = $clog2(MAX_ROWS);
   localparam int CIW   = $clog2(MAX_COLS);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [RIW:0]  ROWS_LIM  = (RIW + 1)'(MAX_ROWS);
   localparam logic [AW-1:0] COLS_A    = AW'(MAX_COLS);
   localparam logic [AW-1:0] LAST_CELL = AW'(DEPTH - 1);
   localparam logic [AW-1:0] LAST_COL  = AW'(MAX_COLS - 1);

   typedef enum logic [4:0] {
      S_INIT  = 5'b00001,
      S_IDLE  = 5'b00010,
      S_EXEC  = 5'b00100,
      S_SWEEP = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   function automatic logic [RIW-1:0] phys_row(input logic [RIW-1:0] row,
                                               input logic [RIW-1:0] top);
      logic [RIW:0] sum;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= ROWS_LIM) begin
         sum = sum - ROWS_LIM;
      end
      return sum[RIW-1:0];
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [RIW-1:0] phys,
                                               input logic [CIW-1:0] col);
      return AW'(phys) * COLS_A + AW'(col);
   endfunction

   logic [7:0]           mem [DEPTH];

   state_type            state_ff, state_in;
   logic [ROW_CNT_W-1:0] row_count_ff;
   logic [COL_CNT_W-1:0] col_count_ff;
   logic [RIW-1:0]       top_ff, top_in;
   logic [ROW_CNT_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_CNT_W-1:0] cur_col_ff, cur_col_in;
   item_type             item_ff, item_in;
   logic [7:0]           rd_data_ff;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        sweep_base_ff, sweep_base_in;
   logic [AW-1:0]        sweep_last_ff, sweep_last_in;
   logic                 sweep_put_ff, sweep_put_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [ROW_CNT_W-1:0] rows;
   logic [COL_CNT_W-1:0] cols;
   logic [ROW_CNT_W-1:0] cr;
   logic [COL_CNT_W-1:0] cc;
   logic                 lf_last;
   logic [RIW-1:0]       top_inc;

   logic [ROW_CNT_W-1:0] ex_row;
   logic [COL_CNT_W-1:0] ex_col;
   logic [RIW-1:0]       ex_top;
   logic                 ex_we;
   logic [ROW_CNT_W-1:0] ex_wrow;
   logic [COL_CNT_W-1:0] ex_wcol;
   logic [7:0]           ex_wdata;
   logic                 ex_scroll;
   logic                 ex_clear;
   logic                 ex_put_after;
   logic [7:0]           ex_rd_char;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [7:0]           mem_wdata;
   logic [AW-1:0]        rd_addr;
   logic                 slot_free;
   logic                 pop;

   // Register values outside the usable range act as if clamped.
   always_comb begin
      if (row_count_ff == '0) begin
         rows = ROW_CNT_W'(1);
      end else if (int'(row_count_ff) > MAX_ROWS) begin
         rows = ROW_CNT_W'(MAX_ROWS);
      end else begin
         rows = row_count_ff;
      end
      if (col_count_ff == '0) begin
         cols = COL_CNT_W'(1);
      end else if (int'(col_count_ff) > MAX_COLS) begin
         cols = COL_CNT_W'(MAX_COLS);
      end else begin
         cols = col_count_ff;
      end
   end

   // The cursor is pulled back inside the grid in case it has shrunk.
   assign cr      = (cur_row_ff >= rows) ? (rows - 7'd1) : cur_row_ff;
   assign cc      = (cur_col_ff > cols) ? cols : cur_col_ff;
   assign lf_last = ({1'b0, cr} + 8'd1) >= {1'b0, rows};
   assign top_inc = phys_row(RIW'(1), top_ff);

   always_comb begin
      ex_row       = cr;
      ex_col       = cc;
      ex_top       = top_ff;
      ex_we        = 1'b0;
      ex_wrow      = cr;
      ex_wcol      = cc;
      ex_wdata     = CHAR_SPACE;
      ex_scroll    = 1'b0;
      ex_clear     = 1'b0;
      ex_put_after = 1'b0;
      ex_rd_char   = 8'd0;
      case (item_ff.op)
         OP_READ: begin
            if (({1'b0, item_ff.read_row} < rows) && ({1'b0, item_ff.read_col} < cols)) begin
               ex_rd_char = rd_data_ff;
            end
         end
         OP_BS: begin
            if (cc != '0) begin
               ex_col  = cc - 8'd1;
               ex_we   = 1'b1;
               ex_wcol = cc - 8'd1;
            end else if (cr != '0) begin
               ex_row  = cr - 7'd1;
               ex_col  = cols - 8'd1;
               ex_we   = 1'b1;
               ex_wrow = cr - 7'd1;
               ex_wcol = cols - 8'd1;
            end
         end
         OP_CR: begin
            ex_col = '0;
         end
         OP_LF: begin
            ex_col = '0;
            if (lf_last) begin
               ex_row    = rows - 7'd1;
               ex_top    = top_inc;
               ex_scroll = 1'b1;
            end else begin
               ex_row = cr + 7'd1;
            end
         end
         OP_FF: begin
            ex_row   = '0;
            ex_col   = '0;
            ex_top   = '0;
            ex_clear = 1'b1;
         end
         OP_PUT: begin
            ex_wdata = item_ff.char_code;
            if (cc >= cols) begin
               ex_col = 8'd1;
               if (lf_last) begin
                  // The character lands in column 0 while the new row is cleared.
                  ex_row       = rows - 7'd1;
                  ex_top       = top_inc;
                  ex_scroll    = 1'b1;
                  ex_put_after = 1'b1;
               end else begin
                  ex_row  = cr + 7'd1;
                  ex_we   = 1'b1;
                  ex_wrow = cr + 7'd1;
                  ex_wcol = '0;
               end
            end else begin
               ex_col = cc + 8'd1;
               ex_we  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = q_valid && ((state_ff == S_IDLE) || ((state_ff == S_DONE) && slot_free));
   assign q_pop     = pop;
   assign rd_addr   = cell_addr(phys_row(RIW'(q_item.read_row), top_ff), CIW'(q_item.read_col));

   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      sweep_base_in = sweep_base_ff;
      sweep_last_in = sweep_last_ff;
      sweep_put_in  = sweep_put_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = cell_addr(phys_row(RIW'(ex_wrow), top_ff), CIW'(ex_wcol));
      mem_wdata     = ex_wdata;
      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = 8'd0;
            cnt_in    = cnt_ff + AW'(1);
            if (cnt_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (pop) begin
               item_in  = q_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            mem_we     = ex_we;
            top_in     = ex_top;
            cur_row_in = ex_row;
            cur_col_in = ex_col;
            res_in     = '{read_char:  ex_rd_char,
                           cursor_row: 6'(ex_row),
                           cursor_col: ex_col,
                           scrolled:   ex_scroll,
                           cleared:    ex_clear};
            cnt_in       = '0;
            sweep_put_in = ex_put_after;
            if (ex_clear) begin
               sweep_base_in = '0;
               sweep_last_in = LAST_CELL;
               state_in      = S_SWEEP;
            end else if (ex_scroll) begin
               sweep_base_in = cell_addr(phys_row(RIW'(rows - 7'd1), top_inc), '0);
               sweep_last_in = LAST_COL;
               state_in      = S_SWEEP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_base_ff + cnt_ff;
            mem_wdata = (sweep_put_ff && (cnt_ff == '0)) ? item_ff.char_code : 8'd0;
            cnt_in    = cnt_ff + AW'(1);
            if (cnt_ff == sweep_last_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               if (pop) begin
                  item_in  = q_item;
                  state_in = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         top_ff       <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         row_count_ff <= ROW_COUNT_RESET;
         col_count_ff <= COL_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         top_ff       <= top_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ROW_COUNT: row_count_ff <= csr_wdata[ROW_CNT_W-1:0];
               CSR_COL_COUNT: col_count_ff <= csr_wdata[COL_CNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      sweep_base_ff <= sweep_base_in;
      sweep_last_ff <= sweep_last_in;
      sweep_put_ff  <= sweep_put_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign status.init_busy = (state_ff == S_INIT);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

endmodule

### rtl/text_console_cursor_engine_core.sv
// Character-cell console engine with a cursor over a ring of text rows.
// Request channel (req_valid, req_stall, req_data): each transaction either
// puts one byte (backspace, carriage return, line feed, form feed, any other
// byte stored, zero ignored) or reads one stored cell. Response channel
// (rsp_valid, rsp_stall, rsp_data) returns exactly one transaction per
// request, in order, carrying the cell read, the cursor after the request
// and scroll/clear flags. row_count and col_count are written through
// csr_we/csr_index/csr_wdata; the user must write them only while no request
// is outstanding, which the block does not enforce. A request executes on the
// text memory in S_EXEC; a scroll (line feed, or a put that wraps at the
// bottom) then clears the new row of MAX_COLS cells in S_SWEEP and a form feed
// all MAX_ROWS*MAX_COLS cells, one memory write per cycle; in S_DONE the
// result goes to the output register while the next queued request can
// already be taken. After reset all MAX_ROWS*MAX_COLS cells of the text
// memory are cleared while req_stall stays high. A two-entry queue sits
// between the decoder and the executing side; when rsp_stall holds the output
// register the executing side waits, the queue fills and req_stall rises.
module text_console_cursor_engine_core
   import tcce_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   back_status_type status;
   logic            q_valid;
   item_type        q_item;
   logic            q_pop;

   tcce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .status    (status),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   tcce_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcce_pkg::*;

   localparam int ROWS_MAX    = 64;
   localparam int COLS_MAX    = 128;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PRINT_CAP   = 60;
   localparam int HOLD_CYCLES = 150;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Mirror of the console: text store, ring offset, cursor and geometry.
   logic [7:0]           screen [ROWS_MAX*COLS_MAX];
   int unsigned          top_row;
   int unsigned          cur_row;
   int unsigned          cur_col;
   logic [ROW_CNT_W-1:0] row_setting;
   logic [COL_CNT_W-1:0] col_setting;

   rsp_type owed_reports [$];
   int      error_count;
   int      cycle_count;
   bit      steady;
   bit      hold_ask;
   int      hold_left;

   text_console_cursor_engine_core #(
      .MAX_ROWS(ROWS_MAX),
      .MAX_COLS(COLS_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic int unsigned rows_in_use();
      if (row_setting == 0) return 1;
      if (row_setting > ROWS_MAX) return ROWS_MAX;
      return 32'(row_setting);
   endfunction

   function automatic int unsigned cols_in_use();
      if (col_setting == 0) return 1;
      if (col_setting > COLS_MAX) return COLS_MAX;
      return 32'(col_setting);
   endfunction

   function automatic int unsigned cell_of(int unsigned r, int unsigned c);
      return ((r + top_row) % ROWS_MAX) * COLS_MAX + (c % COLS_MAX);
   endfunction

   // Moves to the start of the next row; at the bottom the ring advances and
   // the row that comes into view is blanked across the full width.
   function automatic bit advance_line(int unsigned rows);
      int unsigned base;
      cur_col = 0;
      if (cur_row + 1 >= rows) begin
         top_row = (top_row + 1) % ROWS_MAX;
         cur_row = rows - 1;
         base = cell_of(cur_row, 0);
         for (int c = 0; c < COLS_MAX; c++) screen[base + c] = 8'h00;
         return 1'b1;
      end
      cur_row++;
      return 1'b0;
   endfunction

   function automatic rsp_type console_apply(req_type it);
      int unsigned rows;
      int unsigned cols;
      rsp_type     rep;
      rows = rows_in_use();
      cols = cols_in_use();
      rep = '0;
      // A grid shrunk since the last transaction pulls the cursor back inside.
      if (cur_row >= rows) cur_row = rows - 1;
      if (cur_col > cols) cur_col = cols;
      if (it.cmd == CMD_READ) begin
         if (it.read_row < rows && it.read_col < cols)
            rep.read_char = screen[cell_of(it.read_row, it.read_col)];
      end else begin
         case (it.char_code)
            CHAR_NUL: ;
            CHAR_BS: begin
               if (cur_col > 0) begin
                  cur_col--;
                  screen[cell_of(cur_row, cur_col)] = CHAR_SPACE;
               end else if (cur_row > 0) begin
                  cur_row--;
                  cur_col = cols - 1;
                  screen[cell_of(cur_row, cur_col)] = CHAR_SPACE;
               end
            end
            CHAR_CR: cur_col = 0;
            CHAR_LF: rep.scrolled = advance_line(rows);
            CHAR_FF: begin
               foreach (screen[i]) screen[i] = 8'h00;
               top_row = 0;
               cur_row = 0;
               cur_col = 0;
               rep.cleared = 1'b1;
            end
            default: begin
               if (cur_col >= cols) rep.scrolled = advance_line(rows);
               screen[cell_of(cur_row, cur_col)] = it.char_code;
               cur_col++;
            end
         endcase
      end
      rep.cursor_row = cur_row[5:0];
      rep.cursor_col = cur_col[7:0];
      return rep;
   endfunction

   // Mostly text with line control and reads of cells inside the grid, with
   // a few reads anywhere and arbitrary bytes.
   function automatic req_type text_item();
      req_type     it;
      int unsigned rows;
      int unsigned cols;
      int unsigned pick;
      rows = rows_in_use();
      cols = cols_in_use();
      it.read_row = 6'($urandom_range(63));
      it.read_col = 7'($urandom_range(127));
      it.char_code = 8'($urandom_range(255));
      pick = $urandom_range(199);
      if (pick < 50) begin
         it.cmd = CMD_READ;
         if ($urandom_range(9) != 0) begin
            it.read_row = 6'($urandom_range(rows - 1));
            it.read_col = 7'($urandom_range(cols - 1));
         end
      end else begin
         it.cmd = CMD_PUT;
         if (pick < 66) it.char_code = CHAR_LF;
         else if (pick < 74) it.char_code = CHAR_CR;
         else if (pick < 88) it.char_code = CHAR_BS;
         else if (pick < 91) it.char_code = CHAR_NUL;
         else if (pick == 91) it.char_code = CHAR_FF;
         else if (pick < 150) it.char_code = 8'($urandom_range(32, 126));
      end
      return it;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("mismatch at cycle %0d: %s got %0d expected %0d",
                  cycle_count, what, got, want);
   endtask

   task automatic send_item(req_type it);
      while (!steady && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      owed_reports.push_back(console_apply(it));
   endtask

   task automatic put_char(logic [7:0] ch);
      req_type it;
      it.cmd = CMD_PUT;
      it.char_code = ch;
      it.read_row = 6'($urandom_range(63));
      it.read_col = 7'($urandom_range(127));
      send_item(it);
   endtask

   task automatic read_cell(int r, int c);
      req_type it;
      it.cmd = CMD_READ;
      it.char_code = 8'($urandom_range(255));
      it.read_row = r[5:0];
      it.read_col = c[6:0];
      send_item(it);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_reports.size() != 0) @(posedge clock);
   endtask

   task automatic set_geometry(int rows, int cols);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_ROW_COUNT;
      csr_wdata <= rows[7:0];
      @(posedge clock);
      row_setting = rows[6:0];
      csr_index <= CSR_COL_COUNT;
      csr_wdata <= cols[7:0];
      @(posedge clock);
      col_setting = cols[7:0];
      csr_we <= 1'b0;
   endtask

   task automatic apply_reset();
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_ROW_COUNT;
      csr_wdata <= '0;
      reset <= 1'b1;
      foreach (screen[i]) screen[i] = 8'h00;
      top_row = 0;
      cur_row = 0;
      cur_col = 0;
      row_setting = ROW_COUNT_RESET;
      col_setting = COL_COUNT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   endtask

   // Runs on the geometry left by reset.
   task automatic test_reset_geometry();
      put_char(CHAR_BS);
      put_char(CHAR_NUL);
      read_cell(63, 127);
      read_cell(23, 79);
      put_char(8'hFF);
      put_char(8'h41);
      read_cell(0, 0);
      read_cell(0, 1);
      put_char(CHAR_CR);
      put_char(CHAR_LF);
      // Backspace from the start of a row wraps to the end of the one above.
      put_char(CHAR_BS);
      read_cell(0, 79);
      put_char(CHAR_FF);
      read_cell(0, 0);
   endtask

   task automatic test_tiny_grid();
      set_geometry(1, 1);
      put_char(8'h78);
      put_char(8'h79);
      put_char(CHAR_LF);
      read_cell(0, 0);
      read_cell(0, 1);
   endtask

   task automatic test_register_clamp();
      set_geometry(127, 255);
      read_cell(63, 127);
      put_char(CHAR_LF);
      put_char(8'h7A);
      set_geometry(0, 0);
      put_char(CHAR_NUL);
      read_cell(0, 0);
   endtask

   task automatic test_random_text();
      int phase_rows [9] = '{24, 64, 2, 200, 5, 64, 3, 1, 9};
      int phase_cols [9] = '{80, 128, 3, 255, 128, 7, 1, 50, 33};
      for (int p = 0; p < 9; p++) begin
         set_geometry(phase_rows[p], phase_cols[p]);
         repeat (100) send_item(text_item());
      end
   endtask

   task automatic test_steady_stream();
      set_geometry(12, 40);
      steady = 1'b1;
      repeat (150) send_item(text_item());
      wait_idle();
      steady = 1'b0;
   endtask

   // The receiver holds off while transactions keep coming, so the block fills
   // and stalls its input; the sender waits for everything owed, then repeats.
   task automatic test_back_pressure();
      hold_ask = 1'b1;
      repeat (40) send_item(text_item());
      wait_idle();
      hold_ask = 1'b1;
      repeat (20) send_item(text_item());
   endtask

   initial begin
      rsp_stall <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 31);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (owed_reports.size() == 0) begin
            report_mismatch("unexpected transaction, cursor_col",
                            longint'(rsp_data.cursor_col), longint'(0));
         end else begin
            want = owed_reports.pop_front();
            if (rsp_data.read_char !== want.read_char)
               report_mismatch("read_char", longint'(rsp_data.read_char),
                               longint'(want.read_char));
            if (rsp_data.cursor_row !== want.cursor_row)
               report_mismatch("cursor_row", longint'(rsp_data.cursor_row),
                               longint'(want.cursor_row));
            if (rsp_data.cursor_col !== want.cursor_col)
               report_mismatch("cursor_col", longint'(rsp_data.cursor_col),
                               longint'(want.cursor_col));
            if (rsp_data.scrolled !== want.scrolled)
               report_mismatch("scrolled", longint'(rsp_data.scrolled),
                               longint'(want.scrolled));
            if (rsp_data.cleared !== want.cleared)
               report_mismatch("cleared", longint'(rsp_data.cleared),
                               longint'(want.cleared));
         end
      end
   end

   initial begin
      error_count = 0;
      cycle_count = 0;
      steady = 1'b0;
      hold_ask = 1'b0;
      hold_left = 0;
      apply_reset();
      test_reset_geometry();
      test_tiny_grid();
      test_register_clamp();
      test_random_text();
      test_steady_stream();
      test_back_pressure();
      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/tcce_pkg.sv
rtl/tcce_front.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine_core.sv
bench/tb.sv
